// ----- rtl/core/i2cm_pkg.sv -----
// Shared types, codes and reset constants of the I2C master transaction engine.
package i2cm_pkg;

	// Configuration register indexes and reset values
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_LIMIT = 1'd1;
	localparam logic [15:0] PHASE_TICKS_RST   = 16'd12;
	localparam logic [15:0] STRETCH_LIMIT_RST = 16'd5000;

	// Command codes carried on s_tuser
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// Bits per byte on the bus
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'd0,
		PH_SWAIT = 5'd1,
		PH_S1    = 5'd2,
		PH_S2    = 5'd3,
		PH_S3    = 5'd4,
		PH_WB1   = 5'd5,
		PH_WBSCL = 5'd6,
		PH_WB2   = 5'd7,
		PH_WA1   = 5'd8,
		PH_WASCL = 5'd9,
		PH_WA2   = 5'd10,
		PH_WA3   = 5'd11,
		PH_WDATA = 5'd12,
		PH_RB1   = 5'd13,
		PH_RBSCL = 5'd14,
		PH_RB2   = 5'd15,
		PH_RA1   = 5'd16,
		PH_RASCL = 5'd17,
		PH_RA2   = 5'd18,
		PH_RA3   = 5'd19,
		PH_T1    = 5'd20,
		PH_TSCL  = 5'd21,
		PH_T2    = 5'd22,
		PH_T3    = 5'd23
	} phase_t;

	// One input transaction
	typedef struct packed {
		logic [1:0] opcode;
		logic [6:0] target_addr;
		logic       read_not_write;
		logic [7:0] byte_count;
		logic [7:0] write_byte;
		logic       scl_in;
		logic       sda_in;
	} item_t;

	// One result transaction
	typedef struct packed {
		logic       scl_drive_low;
		logic       sda_drive_low;
		logic       busy_res;
		logic       need_write_byte;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       read_last;
		logic       done_res;
		logic       nack_error;
	} res_t;

endpackage

// ----- rtl/core/i2cm_fsm.sv -----
// Bus sequencer: state registers and the single-pass next-state and result logic.
module i2cm_fsm
	import i2cm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  item_t       item,
	input  logic [15:0] phase_ticks,
	input  logic [15:0] stretch_limit,
	output res_t        res
);

	phase_t      phase_q, phase_d;
	logic [15:0] delay_q, delay_d;
	logic [15:0] stretch_q, stretch_d;
	logic [7:0]  shift_q, shift_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  bytes_q, bytes_d;
	logic        is_read_q, is_read_d;
	logic        ack_q, ack_d;
	logic        scl_low_q, scl_low_d;
	logic        sda_low_q, sda_low_d;

	logic        go;
	logic [15:0] dly_inc;
	logic        dly_over;
	logic [15:0] str_inc;
	logic        scl_ok;
	logic [3:0]  bit_inc;
	logic [7:0]  bytes_dec;
	logic [7:0]  rd_shift;
	logic        rvalid, rlast, done, nerr;
	logic [7:0]  rbyte;

	// Hold state until a transaction is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			delay_q   <= '0;
			stretch_q <= '0;
			shift_q   <= '0;
			bit_q     <= '0;
			bytes_q   <= '0;
			is_read_q <= 1'b0;
			ack_q     <= 1'b0;
			scl_low_q <= 1'b0;
			sda_low_q <= 1'b0;
		end else if (advance) begin
			phase_q   <= phase_d;
			delay_q   <= delay_d;
			stretch_q <= stretch_d;
			shift_q   <= shift_d;
			bit_q     <= bit_d;
			bytes_q   <= bytes_d;
			is_read_q <= is_read_d;
			ack_q     <= ack_d;
			scl_low_q <= scl_low_d;
			sda_low_q <= sda_low_d;
		end
	end

	// Advance the bus sequence by one tick
	always_comb begin
		phase_d   = phase_q;
		delay_d   = delay_q;
		stretch_d = stretch_q;
		shift_d   = shift_q;
		bit_d     = bit_q;
		bytes_d   = bytes_q;
		is_read_d = is_read_q;
		ack_d     = ack_q;
		scl_low_d = scl_low_q;
		sda_low_d = sda_low_q;
		go        = 1'b0;
		rvalid    = 1'b0;
		rlast     = 1'b0;
		rbyte     = '0;
		done      = 1'b0;
		nerr      = 1'b0;

		dly_inc   = delay_q + 16'd1;
		dly_over  = (dly_inc >= phase_ticks);
		str_inc   = stretch_q + 16'd1;
		scl_ok    = item.scl_in || (str_inc >= stretch_limit);
		bit_inc   = bit_q + 4'd1;
		bytes_dec = bytes_q - 8'd1;
		rd_shift  = {shift_q[6:0], item.sda_in};

		case (phase_q)
			PH_IDLE: begin
				if (item.opcode == OP_START) begin
					if (item.read_not_write && item.byte_count == 8'd0) begin
						done = 1'b1;
					end else begin
						shift_d   = {item.target_addr, item.read_not_write};
						bit_d     = '0;
						bytes_d   = item.byte_count;
						is_read_d = item.read_not_write;
						ack_d     = 1'b1;
						scl_low_d = 1'b0;
						sda_low_d = 1'b0;
						phase_d   = PH_SWAIT;
						go        = 1'b1;
					end
				end
			end
			PH_SWAIT, PH_WBSCL, PH_WASCL, PH_RBSCL, PH_RASCL, PH_TSCL: begin
				// Wait out a clock stretch, bounded by the stretch limit
				if (scl_ok) begin
					go = 1'b1;
					case (phase_q)
						PH_SWAIT: phase_d = PH_S1;
						PH_WBSCL: phase_d = PH_WB2;
						PH_WASCL: phase_d = PH_WA2;
						PH_RBSCL: phase_d = PH_RB2;
						PH_RASCL: phase_d = PH_RA2;
						default:  phase_d = PH_T2;
					endcase
				end else begin
					stretch_d = str_inc;
				end
			end
			PH_WDATA: begin
				if (item.opcode == OP_WRITE) begin
					shift_d   = item.write_byte;
					bytes_d   = bytes_dec;
					bit_d     = '0;
					sda_low_d = ~item.write_byte[7];
					phase_d   = PH_WB1;
					go        = 1'b1;
				end
			end
			default: begin
				// Timed phases: count the delay, act when it runs out
				if (dly_over) begin
					go = 1'b1;
					case (phase_q)
						PH_S1: begin
							sda_low_d = 1'b1;
							phase_d   = PH_S2;
						end
						PH_S2: begin
							scl_low_d = 1'b1;
							phase_d   = PH_S3;
						end
						PH_S3: begin
							bit_d     = '0;
							sda_low_d = ~shift_q[7];
							phase_d   = PH_WB1;
						end
						PH_WB1, PH_WA1, PH_RB1, PH_RA1, PH_T1: begin
							scl_low_d = 1'b0;
							case (phase_q)
								PH_WB1:  phase_d = PH_WBSCL;
								PH_WA1:  phase_d = PH_WASCL;
								PH_RB1:  phase_d = PH_RBSCL;
								PH_RA1:  phase_d = PH_RASCL;
								default: phase_d = PH_TSCL;
							endcase
						end
						PH_WB2: begin
							scl_low_d = 1'b1;
							shift_d   = {shift_q[6:0], 1'b0};
							bit_d     = bit_inc;
							if (bit_inc < BITS_PER_BYTE) begin
								sda_low_d = ~shift_q[6];
								phase_d   = PH_WB1;
							end else begin
								sda_low_d = 1'b0;
								phase_d   = PH_WA1;
							end
						end
						PH_WA2: begin
							if (item.sda_in) begin
								ack_d = 1'b0;
							end
							scl_low_d = 1'b1;
							phase_d   = PH_WA3;
						end
						PH_WA3: begin
							if (!ack_q || (!is_read_q && bytes_q == 8'd0)) begin
								sda_low_d = 1'b1;
								phase_d   = PH_T1;
							end else if (is_read_q) begin
								sda_low_d = 1'b0;
								shift_d   = '0;
								bit_d     = '0;
								phase_d   = PH_RB1;
							end else begin
								phase_d = PH_WDATA;
							end
						end
						PH_RB2: begin
							shift_d   = rd_shift;
							scl_low_d = 1'b1;
							bit_d     = bit_inc;
							if (bit_inc < BITS_PER_BYTE) begin
								phase_d = PH_RB1;
							end else begin
								rvalid    = 1'b1;
								rbyte     = rd_shift;
								rlast     = (bytes_q == 8'd1);
								sda_low_d = ~rlast;
								phase_d   = PH_RA1;
							end
						end
						PH_RA2: begin
							scl_low_d = 1'b1;
							sda_low_d = 1'b0;
							phase_d   = PH_RA3;
						end
						PH_RA3: begin
							bytes_d = bytes_dec;
							if (bytes_dec != 8'd0) begin
								sda_low_d = 1'b0;
								shift_d   = '0;
								bit_d     = '0;
								phase_d   = PH_RB1;
							end else begin
								sda_low_d = 1'b1;
								phase_d   = PH_T1;
							end
						end
						PH_T2: begin
							sda_low_d = 1'b0;
							phase_d   = PH_T3;
						end
						PH_T3: begin
							done    = 1'b1;
							nerr    = ~ack_q;
							phase_d = PH_IDLE;
						end
						default: begin
							// Unused codes fall back to idle with the lines released
							scl_low_d = 1'b0;
							sda_low_d = 1'b0;
							phase_d   = PH_IDLE;
						end
					endcase
				end else begin
					delay_d = dly_inc;
				end
			end
		endcase

		// Entering a phase restarts both counters
		if (go) begin
			delay_d   = '0;
			stretch_d = '0;
		end
	end

	// Result of this tick, showing the state after it
	always_comb begin
		res.scl_drive_low   = scl_low_d;
		res.sda_drive_low   = sda_low_d;
		res.busy_res        = (phase_d != PH_IDLE);
		res.need_write_byte = (phase_d == PH_WDATA);
		res.read_byte       = rbyte;
		res.read_valid      = rvalid;
		res.read_last       = rlast;
		res.done_res        = done;
		res.nack_error      = nerr;
	end

`ifndef ASSERT_OFF
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q == PH_IDLE && item.opcode != OP_START |=> phase_q == PH_IDLE)
		else $error("sequencer left idle without a start command");
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.done_res |-> !res.busy_res)
		else $error("transfer reported done while still busy");
	a_read_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		res.read_valid |-> is_read_q)
		else $error("read byte delivered during a write transfer");
	a_nack_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.nack_error |-> res.done_res)
		else $error("nack flagged without end of transfer");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q) && $stable(delay_q))
		else $error("sequencer moved without a transaction");
`endif

endmodule

// ----- rtl/core/i2cm_out_buf.sv -----
// Result register with a skid stage so a new transaction is taken while a result waits.
module i2cm_out_buf
	import i2cm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  res_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_data
);

	logic out_v_q;
	logic skid_v_q;
	res_t out_d_q;
	res_t skid_d_q;
	logic in_fire;

	assign in_ready  = ~skid_v_q;
	assign in_fire   = in_valid & in_ready;
	assign out_valid = out_v_q;
	assign out_data  = out_d_q;

	// Track occupancy of the output and skid stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (in_fire) begin
			if (out_v_q && !out_ready) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	// Move payload in order: skid drains first
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_ready) begin
				out_d_q <= skid_d_q;
			end
		end else if (in_fire) begin
			if (out_v_q && !out_ready) begin
				skid_d_q <= in_data;
			end else begin
				out_d_q <= in_data;
			end
		end
	end

endmodule

// ----- rtl/core/i2c_master_transaction_engine.sv -----
// Each result is registered in the output stage, or in the skid stage while the output stalls.
// Throughput: one transaction per cycle while the skid is empty; one sequencer pass per tick.
// A two-entry result buffer keeps input accepted while one result waits downstream.
// Reset (arst_n low) returns to idle, releases both lines, empties the buffer and
// restores phase_ticks to 12 and stretch_limit to 5000.
module i2c_master_transaction_engine
	import i2cm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	// Input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [6:0] target_addr, [7] read_not_write, [15:8] byte_count, [23:16] write_byte,
	// [24] scl_in, [25] sda_in, [31:26] zero
	input  logic [31:0]          s_tdata,
	// [1:0] opcode
	input  logic [1:0]           s_tuser,
	// Output stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [0] scl_drive_low, [1] sda_drive_low, [2] busy_res, [3] need_write_byte,
	// [11:4] read_byte, [12] done_res, [13] nack_error, [15:14] zero
	output logic [15:0]          m_tdata,
	// [0] read_valid
	output logic                 m_tuser,
	// read_last
	output logic                 m_tlast
);

	logic [15:0] phase_ticks_q;
	logic [15:0] stretch_limit_q;
	item_t       item;
	res_t        res;
	res_t        res_out;
	logic        advance;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q   <= PHASE_TICKS_RST;
			stretch_limit_q <= STRETCH_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PHASE_TICKS:   phase_ticks_q   <= cfg_data;
				CFG_STRETCH_LIMIT: stretch_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unpack the input transaction
	always_comb begin
		item.opcode         = s_tuser;
		item.target_addr    = s_tdata[6:0];
		item.read_not_write = s_tdata[7];
		item.byte_count     = s_tdata[15:8];
		item.write_byte     = s_tdata[23:16];
		item.scl_in         = s_tdata[24];
		item.sda_in         = s_tdata[25];
	end

	assign advance = s_tvalid & s_tready;

	i2cm_fsm u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.item          (item),
		.phase_ticks   (phase_ticks_q),
		.stretch_limit (stretch_limit_q),
		.res           (res)
	);

	i2cm_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res_out)
	);

	// Pack the result transaction
	assign m_tdata = {2'b00, res_out.nack_error, res_out.done_res, res_out.read_byte,
		res_out.need_write_byte, res_out.busy_res, res_out.sda_drive_low,
		res_out.scl_drive_low};
	assign m_tuser = res_out.read_valid;
	assign m_tlast = res_out.read_last;

endmodule

// ----- dv/i2cm_bus_checker.sv -----
// Bus checker: predicts every status snapshot of the I2C master and compares the output stream.
module i2cm_bus_checker
	import i2cm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [31:0]          s_tdata,
	input  logic [1:0]           s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [15:0]          m_tdata,
	input  logic                 m_tuser,
	input  logic                 m_tlast,
	output int                   mismatches,
	output int                   pending,
	output int                   compared,
	output phase_t               bus_phase
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow registers and sequencer state
	logic [15:0] tick_len = PHASE_TICKS_RST;
	logic [15:0] stretch_max = STRETCH_LIMIT_RST;
	phase_t      ph = PH_IDLE;
	logic [15:0] dly = '0;
	logic [15:0] str = '0;
	logic [7:0]  shreg = '0;
	logic [3:0]  bidx = '0;
	logic [7:0]  left = '0;
	logic        rd = 1'b0;
	logic        acked = 1'b0;
	logic        scl_lo = 1'b0;
	logic        sda_lo = 1'b0;

	res_t status_q[$];
	item_t cmd;
	res_t want, got;
	int n_bad = 0;
	int n_pending = 0;
	int n_compared = 0;

	assign mismatches = n_bad;
	assign pending = n_pending;
	assign compared = n_compared;
	assign bus_phase = ph;

	function automatic void go(phase_t p);
		ph = p;
		dly = '0;
		str = '0;
	endfunction

	function automatic logic delay_over();
		dly = dly + 16'd1;
		return dly >= tick_len;
	endfunction

	// A low SCL counts against the stretch budget; running out proceeds anyway
	function automatic logic scl_ok(logic scl);
		if (scl)
			return 1'b1;
		str = str + 16'd1;
		return str >= stretch_max;
	endfunction

	function automatic void begin_stop();
		sda_lo = 1'b1;
		go(PH_T1);
	endfunction

	function automatic void send_bit();
		sda_lo = !shreg[7];
		go(PH_WB1);
	endfunction

	function automatic void recv_byte();
		sda_lo = 1'b0;
		shreg = '0;
		bidx = '0;
		go(PH_RB1);
	endfunction

	// Advance the sequencer by one tick and build the snapshot it leaves behind
	function automatic res_t step_bus(item_t it);
		res_t r;
		r = '0;
		case (ph)
			PH_IDLE: begin
				if (it.opcode == OP_START) begin
					if (it.read_not_write && it.byte_count == 8'd0) begin
						r.done_res = 1'b1;
					end else begin
						shreg = {it.target_addr, it.read_not_write};
						bidx = '0;
						left = it.byte_count;
						rd = it.read_not_write;
						acked = 1'b1;
						scl_lo = 1'b0;
						sda_lo = 1'b0;
						go(PH_SWAIT);
					end
				end
			end
			PH_SWAIT: if (scl_ok(it.scl_in)) go(PH_S1);
			PH_S1: if (delay_over()) begin
				sda_lo = 1'b1;
				go(PH_S2);
			end
			PH_S2: if (delay_over()) begin
				scl_lo = 1'b1;
				go(PH_S3);
			end
			PH_S3: if (delay_over()) begin
				bidx = '0;
				send_bit();
			end
			PH_WB1: if (delay_over()) begin
				scl_lo = 1'b0;
				go(PH_WBSCL);
			end
			PH_WBSCL: if (scl_ok(it.scl_in)) go(PH_WB2);
			PH_WB2: if (delay_over()) begin
				scl_lo = 1'b1;
				shreg = {shreg[6:0], 1'b0};
				bidx = bidx + 4'd1;
				if (bidx < BITS_PER_BYTE) begin
					send_bit();
				end else begin
					sda_lo = 1'b0;
					go(PH_WA1);
				end
			end
			PH_WA1: if (delay_over()) begin
				scl_lo = 1'b0;
				go(PH_WASCL);
			end
			PH_WASCL: if (scl_ok(it.scl_in)) go(PH_WA2);
			PH_WA2: if (delay_over()) begin
				if (it.sda_in)
					acked = 1'b0;
				scl_lo = 1'b1;
				go(PH_WA3);
			end
			PH_WA3: if (delay_over()) begin
				if (!acked)
					begin_stop();
				else if (rd)
					recv_byte();
				else if (left != 8'd0)
					go(PH_WDATA);
				else
					begin_stop();
			end
			PH_WDATA: if (it.opcode == OP_WRITE) begin
				shreg = it.write_byte;
				left = left - 8'd1;
				bidx = '0;
				send_bit();
			end
			PH_RB1: if (delay_over()) begin
				scl_lo = 1'b0;
				go(PH_RBSCL);
			end
			PH_RBSCL: if (scl_ok(it.scl_in)) go(PH_RB2);
			PH_RB2: if (delay_over()) begin
				shreg = {shreg[6:0], it.sda_in};
				scl_lo = 1'b1;
				bidx = bidx + 4'd1;
				if (bidx < BITS_PER_BYTE) begin
					go(PH_RB1);
				end else begin
					// Last byte of a read gets a NACK, all others an ACK
					r.read_valid = 1'b1;
					r.read_byte = shreg;
					r.read_last = (left == 8'd1);
					sda_lo = !r.read_last;
					go(PH_RA1);
				end
			end
			PH_RA1: if (delay_over()) begin
				scl_lo = 1'b0;
				go(PH_RASCL);
			end
			PH_RASCL: if (scl_ok(it.scl_in)) go(PH_RA2);
			PH_RA2: if (delay_over()) begin
				scl_lo = 1'b1;
				sda_lo = 1'b0;
				go(PH_RA3);
			end
			PH_RA3: if (delay_over()) begin
				left = left - 8'd1;
				if (left != 8'd0)
					recv_byte();
				else
					begin_stop();
			end
			PH_T1: if (delay_over()) begin
				scl_lo = 1'b0;
				go(PH_TSCL);
			end
			PH_TSCL: if (scl_ok(it.scl_in)) go(PH_T2);
			PH_T2: if (delay_over()) begin
				sda_lo = 1'b0;
				go(PH_T3);
			end
			PH_T3: if (delay_over()) begin
				r.done_res = 1'b1;
				r.nack_error = !acked;
				go(PH_IDLE);
			end
			default: begin
				scl_lo = 1'b0;
				sda_lo = 1'b0;
				go(PH_IDLE);
			end
		endcase
		r.scl_drive_low = scl_lo;
		r.sda_drive_low = sda_lo;
		r.busy_res = (ph != PH_IDLE);
		r.need_write_byte = (ph == PH_WDATA);
		return r;
	endfunction

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
			n_bad++;
		end
	endtask

	// Retire result transactions first, then absorb config writes and new ticks
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_len = PHASE_TICKS_RST;
			stretch_max = STRETCH_LIMIT_RST;
			go(PH_IDLE);
			shreg = '0;
			bidx = '0;
			left = '0;
			rd = 1'b0;
			acked = 1'b0;
			scl_lo = 1'b0;
			sda_lo = 1'b0;
			status_q.delete();
			n_pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (status_q.size() == 0) begin
					$display("%0t: unexpected result transaction, tdata %h", $time, m_tdata);
					n_bad++;
				end else begin
					want = status_q.pop_front();
					got = '0;
					got.scl_drive_low = m_tdata[0];
					got.sda_drive_low = m_tdata[1];
					got.busy_res = m_tdata[2];
					got.need_write_byte = m_tdata[3];
					got.read_byte = m_tdata[11:4];
					got.done_res = m_tdata[12];
					got.nack_error = m_tdata[13];
					got.read_valid = m_tuser;
					got.read_last = m_tlast;
					check_field("scl_drive_low", want.scl_drive_low, got.scl_drive_low);
					check_field("sda_drive_low", want.sda_drive_low, got.sda_drive_low);
					check_field("busy_res", want.busy_res, got.busy_res);
					check_field("need_write_byte", want.need_write_byte, got.need_write_byte);
					check_field("read_byte", want.read_byte, got.read_byte);
					check_field("read_valid", want.read_valid, got.read_valid);
					check_field("read_last", want.read_last, got.read_last);
					check_field("done_res", want.done_res, got.done_res);
					check_field("nack_error", want.nack_error, got.nack_error);
					n_compared++;
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_PHASE_TICKS)
					tick_len = cfg_data;
				else if (cfg_index == CFG_STRETCH_LIMIT)
					stretch_max = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				cmd.opcode = s_tuser;
				cmd.target_addr = s_tdata[6:0];
				cmd.read_not_write = s_tdata[7];
				cmd.byte_count = s_tdata[15:8];
				cmd.write_byte = s_tdata[23:16];
				cmd.scl_in = s_tdata[24];
				cmd.sda_in = s_tdata[25];
				status_q.push_back(step_bus(cmd));
			end
			n_pending = status_q.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top: drives ticks and register writes into the I2C master and gives the verdict.
module tb_top
	import i2cm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Reserved opcode, behaves as a plain tick
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_PHASE_TICKS;
	logic [15:0]          cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [31:0]          s_tdata = '0;
	logic [1:0]           s_tuser = OP_TICK;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [15:0]          m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;

	int     mismatches;
	int     pending;
	int     compared;
	phase_t bus_phase;

	// Slave behavior knobs, picked per transfer
	int nack_pct = 0;
	int stretch_pct = 0;
	bit quiet = 1'b0;
	int ticks_sent = 0;
	int starts = 0;
	int n_settings = 1;
	int fails;
	item_t it;

	i2c_master_transaction_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	i2cm_bus_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pending    (pending),
		.compared   (compared),
		.bus_phase  (bus_phase)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the result side now and then, never while quiet
	always @(negedge clk) begin
		m_tready <= quiet || ($urandom_range(0, 99) >= 7);
	end

	function automatic item_t any_item();
		item_t x;
		x.opcode = OP_TICK;
		x.target_addr = 7'($urandom_range(0, 127));
		x.read_not_write = 1'($urandom_range(0, 1));
		x.byte_count = 8'($urandom_range(0, 255));
		x.write_byte = 8'($urandom_range(0, 255));
		x.scl_in = 1'($urandom_range(0, 1));
		x.sda_in = 1'($urandom_range(0, 1));
		return x;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction
	task automatic send_item(input item_t x);
		while (!quiet && $urandom_range(0, 99) < 7) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		if (bus_phase == PH_IDLE && x.opcode == OP_START)
			starts++;
		s_tvalid <= 1'b1;
		s_tuser <= x.opcode;
		s_tdata <= {6'd0, x.sda_in, x.scl_in, x.write_byte, x.byte_count,
			x.read_not_write, x.target_addr};
		do @(posedge clk); while (!s_tready);
		ticks_sent++;
		@(negedge clk);
	endtask

	// Choose the next tick from the predicted bus phase, acting as host and slave
	task automatic pick_tick(input bit may_start, output item_t x);
		int roll;
		x = any_item();
		roll = $urandom_range(0, 99);
		case (bus_phase)
			PH_IDLE: begin
				if (may_start && roll < 60) begin
					x.opcode = OP_START;
					x.byte_count = ($urandom_range(0, 99) < 80) ?
						8'($urandom_range(0, 3)) : 8'($urandom_range(0, 8));
					case ($urandom_range(0, 9))
						0, 1: nack_pct = 25;
						2: nack_pct = 100;
						default: nack_pct = 0;
					endcase
					case ($urandom_range(0, 3))
						2: stretch_pct = 30;
						3: stretch_pct = 90;
						default: stretch_pct = 0;
					endcase
				end else begin
					x.opcode = (roll < 80) ? OP_TICK : (roll < 90) ? OP_WRITE : OP_SPARE;
				end
			end
			PH_WDATA: x.opcode = (roll < 75) ? OP_WRITE : (roll < 85) ? OP_TICK :
				(roll < 93) ? OP_START : OP_SPARE;
			default: x.opcode = (roll < 85) ? OP_TICK : (roll < 92) ? OP_START :
				(roll < 96) ? OP_WRITE : OP_SPARE;
		endcase
		case (bus_phase)
			PH_SWAIT, PH_WBSCL, PH_WASCL, PH_RBSCL, PH_RASCL, PH_TSCL:
				x.scl_in = ($urandom_range(0, 99) >= stretch_pct);
			PH_WA2: x.sda_in = ($urandom_range(0, 99) < nack_pct);
			default: ;
		endcase
	endtask

	task automatic run_transfer(input logic [6:0] addr, input logic rnw, input logic [7:0] cnt,
		input int nack, input int stretch);
		item_t x;
		nack_pct = nack;
		stretch_pct = stretch;
		x = any_item();
		x.opcode = OP_START;
		x.target_addr = addr;
		x.read_not_write = rnw;
		x.byte_count = cnt;
		send_item(x);
		while (bus_phase != PH_IDLE) begin
			pick_tick(1'b0, x);
			send_item(x);
		end
	endtask

	task automatic random_ticks(input int n);
		item_t x;
		for (int k = 0; k < n; k++) begin
			pick_tick(1'b1, x);
			send_item(x);
		end
	endtask

	// Drop valid and hold until every predicted snapshot has come back
	task automatic hold_off();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// Finish the transfer in flight, drain, and let the pipeline go quiet
	task automatic settle();
		item_t x;
		while (bus_phase != PH_IDLE) begin
			pick_tick(1'b0, x);
			send_item(x);
		end
		hold_off();
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(input logic [15:0] ticks, input logic [15:0] limit);
		settle();
		write_reg(CFG_PHASE_TICKS, ticks);
		write_reg(CFG_STRETCH_LIMIT, limit);
		n_settings++;
	endtask

	// Run limit
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Idle-side corner cases at reset timing
		it = any_item();
		send_item(it);
		it = any_item();
		it.opcode = OP_SPARE;
		send_item(it);
		it = any_item();
		it.opcode = OP_WRITE;
		it.write_byte = 8'hFF;
		send_item(it);
		run_transfer(7'h7F, 1'b1, 8'd0, 0, 0);
		run_transfer(7'h00, 1'b0, 8'd0, 0, 0);

		// Shortest delays and stretch budget
		set_regs(16'd1, 16'd1);
		run_transfer(7'h7F, 1'b0, 8'd2, 0, 90);
		run_transfer(7'h2A, 1'b0, 8'd255, 100, 0);
		run_transfer(7'h55, 1'b1, 8'd1, 0, 20);
		run_transfer(7'h13, 1'b1, 8'd3, 0, 0);

		// Zero in both registers
		set_regs(16'd0, 16'd0);
		run_transfer(7'h66, 1'b0, 8'd1, 0, 90);
		run_transfer(7'h19, 1'b1, 8'd2, 0, 90);

		// Largest values: only instant transfers fit
		set_regs(16'hFFFF, 16'hFFFF);
		run_transfer(7'h40, 1'b1, 8'd0, 0, 0);
		it = any_item();
		it.opcode = OP_WRITE;
		it.write_byte = 8'h00;
		send_item(it);
		it = any_item();
		send_item(it);

		// Random traffic over several timings
		set_regs(16'd2, STRETCH_LIMIT_RST);
		random_ticks(250);
		hold_off();
		random_ticks(250);
		set_regs(16'd1, 16'd3);
		quiet = 1'b1;
		random_ticks(500);
		quiet = 1'b0;
		set_regs(16'd3, 16'hFFFF);
		random_ticks(500);
		set_regs(16'd1, 16'd20);
		random_ticks(500);
		settle();

		repeat (10) @(posedge clk);
		fails = mismatches;
		if (pending != 0) begin
			$display("%0t: %0d expected snapshots never arrived", $time, pending);
			fails++;
		end
		$display("Ran %0d ticks with %0d transfer starts across %0d register settings",
			ticks_sent, starts, n_settings);
		$display("Compared %0d bus snapshots field by field", compared);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
